// ===== design/mbe_pkg.sv =====
// ----------------------------------------------------------------------------
// mbe_pkg
// Shared widths, register indexes, reset values and the configuration
// bundle of the escape-time core.
// ----------------------------------------------------------------------------
package mbe_pkg;

   localparam int PIXEL_ROW_W    = 11;
   localparam int PIXEL_COLUMN_W = 12;
   localparam int PIXEL_INDEX_W  = 23;
   localparam int COUNT_W        = 16;
   localparam int WORD_W         = 32;
   localparam int PROD_W         = 2 * WORD_W;

   localparam int REQ_DATA_W     = 24;
   localparam int RSP_DATA_W     = 104;

   localparam int STEP_W         = 28;
   localparam int ROW_LENGTH_W   = 13;
   localparam int CSR_INDEX_W    = 2;
   localparam int CSR_DATA_W     = 28;

   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_RE         = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_IM         = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ITERATION_LIMIT = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_LENGTH      = 2'd3;

   localparam logic [STEP_W-1:0]       STEP_RE_RESET         = 28'd489335;
   localparam logic [STEP_W-1:0]       STEP_IM_RESET         = 28'd497103;
   localparam logic [COUNT_W-1:0]      ITERATION_LIMIT_RESET = 16'd1000;
   localparam logic [ROW_LENGTH_W-1:0] ROW_LENGTH_RESET      = 13'd1920;

   typedef struct packed {
      logic [STEP_W-1:0]       step_re;
      logic [STEP_W-1:0]       step_im;
      logic [COUNT_W-1:0]      iteration_limit;
      logic [ROW_LENGTH_W-1:0] row_length;
   } cfg_type;

endpackage

// ===== design/mbe_cfg.sv =====
// ----------------------------------------------------------------------------
// mbe_cfg
// Configuration register file. Row length writes are clamped to the
// largest supported row length.
// ----------------------------------------------------------------------------
module mbe_cfg #(
   parameter int MAX_ROW_LENGTH = 4096
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [mbe_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [mbe_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output mbe_pkg::cfg_type                   cfg
);

   localparam int RL_FULL_W = $clog2(MAX_ROW_LENGTH + 1);
   localparam int RL_W = (RL_FULL_W < mbe_pkg::ROW_LENGTH_W) ? RL_FULL_W
                                                             : mbe_pkg::ROW_LENGTH_W;

   logic [mbe_pkg::STEP_W-1:0]       step_re_ff, step_re_in;
   logic [mbe_pkg::STEP_W-1:0]       step_im_ff, step_im_in;
   logic [mbe_pkg::COUNT_W-1:0]      limit_ff, limit_in;
   logic [RL_W-1:0]                  row_length_ff, row_length_in;
   logic [mbe_pkg::ROW_LENGTH_W-1:0] rl_value;
   logic [RL_W-1:0]                  rl_clamped;

   always_comb begin
      rl_value = csr_wdata[mbe_pkg::ROW_LENGTH_W-1:0];
      if (32'(rl_value) > 32'(MAX_ROW_LENGTH)) begin
         rl_clamped = RL_W'(MAX_ROW_LENGTH);
      end else begin
         rl_clamped = rl_value[RL_W-1:0];
      end
   end

   always_comb begin
      step_re_in    = step_re_ff;
      step_im_in    = step_im_ff;
      limit_in      = limit_ff;
      row_length_in = row_length_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            mbe_pkg::CSR_STEP_RE:         step_re_in    = csr_wdata[mbe_pkg::STEP_W-1:0];
            mbe_pkg::CSR_STEP_IM:         step_im_in    = csr_wdata[mbe_pkg::STEP_W-1:0];
            mbe_pkg::CSR_ITERATION_LIMIT: limit_in      = csr_wdata[mbe_pkg::COUNT_W-1:0];
            mbe_pkg::CSR_ROW_LENGTH:      row_length_in = rl_clamped;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_re_ff    <= mbe_pkg::STEP_RE_RESET;
         step_im_ff    <= mbe_pkg::STEP_IM_RESET;
         limit_ff      <= mbe_pkg::ITERATION_LIMIT_RESET;
         row_length_ff <= RL_W'(mbe_pkg::ROW_LENGTH_RESET);
      end else begin
         step_re_ff    <= step_re_in;
         step_im_ff    <= step_im_in;
         limit_ff      <= limit_in;
         row_length_ff <= row_length_in;
      end
   end

   assign cfg.step_re         = step_re_ff;
   assign cfg.step_im         = step_im_ff;
   assign cfg.iteration_limit = limit_ff;
   assign cfg.row_length      = mbe_pkg::ROW_LENGTH_W'(row_length_ff);

endmodule

// ===== design/mbe_mul.sv =====
// ----------------------------------------------------------------------------
// mbe_mul
// Shared signed 32 by 32 multiplier with a registered 64-bit product.
// ----------------------------------------------------------------------------
module mbe_mul (
   input  logic                               clock,
   input  logic signed [mbe_pkg::WORD_W-1:0]  mul_a,
   input  logic signed [mbe_pkg::WORD_W-1:0]  mul_b,
   output logic signed [mbe_pkg::PROD_W-1:0]  prod_ff
);

   logic signed [mbe_pkg::PROD_W-1:0] prod_in;

   assign prod_in = mbe_pkg::PROD_W'(mul_a) * mbe_pkg::PROD_W'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

// ===== design/mandelbrot_escape_time_core.sv =====
// ----------------------------------------------------------------------------
// mandelbrot_escape_time_core
// The sequencer handles one pixel at a time and takes a new request only
// when idle. A pixel runs at most iteration_limit iterations; each
// iteration needs three products from the single shared multiplier plus
// an escape test state.
// Reset is synchronous and active high: it idles the sequencer, empties the
// result register and loads the configuration registers with their defaults.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_core #(
   parameter int FRACTION_BITS  = 28,
   parameter int MAX_ROW_LENGTH = 4096
) (
   input  logic                               clock,
   input  logic                               reset,
   // Request channel. tdata fields from bit 0 up: pixel_row[10:0],
   // pixel_column[22:11], zero pad [23].
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [mbe_pkg::REQ_DATA_W-1:0]     req_tdata,
   // Response channel. tdata fields from bit 0 up: pixel_index[22:0],
   // escape_count[38:23], final_real[70:39], final_imag[102:71], zero pad [103].
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [mbe_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // Configuration write port.
   input  logic                               csr_wr_en,
   input  logic [mbe_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [mbe_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int W     = mbe_pkg::WORD_W;
   localparam int PW    = mbe_pkg::PROD_W;
   // Width of a shifted square; the top bits of a 64-bit square that survive
   // the fraction shift.
   localparam int SQ_W  = PW - FRACTION_BITS;
   localparam int CMP_W = (SQ_W + 1 > FRACTION_BITS + 3) ? SQ_W + 1 : FRACTION_BITS + 3;

   // The fixed origin of the plane, -2.5 and -1.0, in wrapped 32-bit form.
   localparam logic [PW-1:0] ORIGIN_RE_FULL = 64'd0 - (64'd5 << (FRACTION_BITS - 1));
   localparam logic [PW-1:0] ORIGIN_IM_FULL = 64'd0 - (64'd1 << FRACTION_BITS);
   localparam logic [W-1:0]  ORIGIN_RE     = ORIGIN_RE_FULL[W-1:0];
   localparam logic [W-1:0]  ORIGIN_IM     = ORIGIN_IM_FULL[W-1:0];
   // Escape radius squared, 2*2, in the fixed-point scale.
   localparam logic [CMP_W-1:0] BAIL       = CMP_W'(4) << FRACTION_BITS;

   // One-hot sequencer. The four load states form c and the pixel index with
   // the shared multiplier; TEST, MUL_XY, MUL_XX and MUL_YY make up one
   // iteration of z = z*z + c.
   typedef enum logic [9:0] {
      ST_IDLE    = 10'b00_0000_0001,
      ST_LD_CRE  = 10'b00_0000_0010,
      ST_LD_CIM  = 10'b00_0000_0100,
      ST_LD_IDX  = 10'b00_0000_1000,
      ST_IDX_CAP = 10'b00_0001_0000,
      ST_TEST    = 10'b00_0010_0000,
      ST_MUL_XY  = 10'b00_0100_0000,
      ST_MUL_XX  = 10'b00_1000_0000,
      ST_MUL_YY  = 10'b01_0000_0000,
      ST_SPARE   = 10'b10_0000_0000
   } state_type;

   state_type                           state_ff, state_in;
   mbe_pkg::cfg_type                    cfg;

   logic [mbe_pkg::PIXEL_ROW_W-1:0]     row_ff, row_in;
   logic [mbe_pkg::PIXEL_COLUMN_W-1:0]  col_ff, col_in;
   logic [mbe_pkg::PIXEL_INDEX_W-1:0]   index_ff, index_in;
   logic [mbe_pkg::COUNT_W-1:0]         count_ff, count_in;
   logic [W-1:0]                        c_re_ff, c_re_in;
   logic [W-1:0]                        c_im_ff, c_im_in;
   logic [W-1:0]                        zr_ff, zr_in;
   logic [W-1:0]                        zi_ff, zi_in;
   logic [SQ_W-1:0]                     re2_ff, re2_in;
   logic [SQ_W-1:0]                     im2_ff, im2_in;
   logic                                rsp_tvalid_ff, rsp_tvalid_in;
   logic [mbe_pkg::RSP_DATA_W-1:0]      rsp_tdata_ff, rsp_tdata_in;

   logic signed [W-1:0]                 mul_a;
   logic signed [W-1:0]                 mul_b;
   logic signed [PW-1:0]                prod_ff;
   logic signed [PW-1:0]                prod_sq;
   logic signed [PW-1:0]                prod_cross;
   logic [PW-1:0]                       re2_ext;
   logic [PW-1:0]                       im2_ext;
   logic [W-1:0]                        new_re;
   logic [CMP_W-1:0]                    mag_sum;
   logic                                escaped;
   logic                                iterate;

   mbe_cfg #(
      .MAX_ROW_LENGTH (MAX_ROW_LENGTH)
   ) u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   mbe_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (prod_ff)
   );

   // Operand selection for the shared multiplier. The product is registered,
   // so each state consumes what the previous state issued.
   always_comb begin
      unique case (state_ff)
         ST_LD_CRE: begin
            mul_a = W'(col_ff);
            mul_b = W'(cfg.step_re);
         end
         ST_LD_CIM: begin
            mul_a = W'(row_ff);
            mul_b = W'(cfg.step_im);
         end
         ST_LD_IDX: begin
            mul_a = W'(row_ff);
            mul_b = W'(cfg.row_length);
         end
         ST_MUL_XY: begin
            mul_a = zr_ff;
            mul_b = zr_ff;
         end
         ST_MUL_XX: begin
            mul_a = zi_ff;
            mul_b = zi_ff;
         end
         default: begin
            // TEST issues the cross product zr*zi with the old z.
            mul_a = zr_ff;
            mul_b = zi_ff;
         end
      endcase
   end

   // Fixed-point rescaling of products. Squares drop the full fraction; the
   // cross product drops one bit less, which doubles it. Both round toward
   // minus infinity through the arithmetic shift.
   assign prod_sq    = prod_ff >>> FRACTION_BITS;
   assign prod_cross = prod_ff >>> (FRACTION_BITS - 1);

   // The escape test uses the unwrapped squares, while the next real part
   // only needs their low word since it wraps to 32 bits anyway.
   assign re2_ext = PW'(re2_ff);
   assign im2_ext = PW'(im2_ff);
   assign new_re  = re2_ext[W-1:0] - im2_ext[W-1:0] + c_re_ff;
   assign mag_sum = CMP_W'(re2_ff) + CMP_W'(im2_ff);
   assign escaped = (mag_sum >= BAIL);
   assign iterate = !escaped && (count_ff < cfg.iteration_limit);

   always_comb begin
      state_in      = state_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      index_in      = index_ff;
      count_in      = count_ff;
      c_re_in       = c_re_ff;
      c_im_in       = c_im_ff;
      zr_in         = zr_ff;
      zi_in         = zi_ff;
      re2_in        = re2_ff;
      im2_in        = im2_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;

      // The result register empties when its transaction completes; a new
      // result loaded in the same cycle overrides this below.
      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               row_in   = req_tdata[mbe_pkg::PIXEL_ROW_W-1:0];
               col_in   = req_tdata[mbe_pkg::PIXEL_ROW_W +: mbe_pkg::PIXEL_COLUMN_W];
               count_in = '0;
               zr_in    = '0;
               zi_in    = '0;
               re2_in   = '0;
               im2_in   = '0;
               state_in = ST_LD_CRE;
            end
         end
         ST_LD_CRE: begin
            state_in = ST_LD_CIM;
         end
         ST_LD_CIM: begin
            // c_re sits at the pixel center: origin plus half a step plus
            // column times step, wrapped to 32 bits.
            c_re_in  = ORIGIN_RE + W'(cfg.step_re >> 1) + prod_ff[W-1:0];
            state_in = ST_LD_IDX;
         end
         ST_LD_IDX: begin
            c_im_in  = ORIGIN_IM + W'(cfg.step_im >> 1) + prod_ff[W-1:0];
            state_in = ST_IDX_CAP;
         end
         ST_IDX_CAP: begin
            index_in = prod_ff[mbe_pkg::PIXEL_INDEX_W-1:0]
                       + mbe_pkg::PIXEL_INDEX_W'(col_ff);
            state_in = ST_TEST;
         end
         ST_TEST: begin
            if (iterate) begin
               // The multiplier reads the old zr this cycle, so the new real
               // part can already be written back.
               zr_in    = new_re;
               count_in = count_ff + 1'b1;
               state_in = ST_MUL_XY;
            end else if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {1'b0, zi_ff, zr_ff, count_ff, index_ff};
               state_in      = ST_IDLE;
            end
         end
         ST_MUL_XY: begin
            zi_in    = prod_cross[W-1:0] + c_im_ff;
            state_in = ST_MUL_XX;
         end
         ST_MUL_XX: begin
            re2_in   = prod_sq[SQ_W-1:0];
            state_in = ST_MUL_YY;
         end
         ST_MUL_YY: begin
            im2_in   = prod_sq[SQ_W-1:0];
            state_in = ST_TEST;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff       <= row_in;
      col_ff       <= col_in;
      index_ff     <= index_in;
      count_ff     <= count_in;
      c_re_ff      <= c_re_in;
      c_im_ff      <= c_im_in;
      zr_ff        <= zr_in;
      zi_ff        <= zi_in;
      re2_ff       <= re2_in;
      im2_ff       <= im2_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   // The sequencer takes a new transaction only when idle; a finished result
   // waits in its own register, so the next pixel can start meanwhile.
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // While a pixel is in flight its count never passes the limit.
   a_count_within_limit : assert property (
      @(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (count_ff <= cfg.iteration_limit)
   ) else $error("escape count ran past the iteration limit");

   // A result that stopped short of the limit must have escaped.
   a_short_count_escaped : assert property (
      @(posedge clock) disable iff (reset)
      ($rose(rsp_tvalid_ff) && (rsp_tdata_ff[38:23] < cfg.iteration_limit)) |-> escaped
   ) else $error("result stopped before the limit without escaping");

   // The squares are only taken after an escape test let the iteration go on,
   // with MUL_XY lying between TEST and MUL_XX.
   a_iteration_order : assert property (
      @(posedge clock) disable iff (reset)
      (state_ff == ST_MUL_XX) |-> ($past(state_ff, 2) == ST_TEST)
   ) else $error("iteration steps out of order");

endmodule
